@@ rtl/sptma_pkg.sv @@
// Package for the sparse triplet matrix adder.
// Holds the payload structs, the queued operation struct, sizing constants and the CSR index, list and status codes.
// No dependencies.
`default_nettype none
package sptma_pkg;

   localparam int CAPACITY    = 32;
   localparam int MAX_OUT     = 64;
   localparam int CAP_USE     = (CAPACITY > MAX_OUT) ? MAX_OUT : CAPACITY;
   localparam int STORE_DEPTH = 32;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int NOUT_W      = $clog2(MAX_OUT + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] CSR_FIRST_ROWS  = 2'd0;
   localparam logic [1:0] CSR_FIRST_COLS  = 2'd1;
   localparam logic [1:0] CSR_SECOND_ROWS = 2'd2;
   localparam logic [1:0] CSR_SECOND_COLS = 2'd3;

   localparam logic LIST_FIRST  = 1'b0;
   localparam logic LIST_SECOND = 1'b1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_MISMATCH = 1'b1;

   typedef struct packed {
      logic               which_list;
      logic [15:0]        row;
      logic [15:0]        col;
      logic signed [31:0] value;
      logic               no_entry;
      logic               last_of_list;
   } req_type;

   typedef struct packed {
      logic [15:0]        out_row;
      logic [15:0]        out_col;
      logic signed [31:0] out_value;
      logic               out_valid;
      logic               status;
      logic               out_last;
   } rsp_type;

   typedef struct packed {
      logic        wr;
      logic        list;
      logic        merge;
      logic [63:0] entry;
   } op_type;

endpackage
`default_nettype wire

@@ rtl/sparse_triplet_matrix_add.sv @@
// Top level of the sparse triplet matrix adder.
// Depends on sptma_pkg, sptma_front, sptma_queue and sptma_back.
//
// Usage: load triplets of the first and second matrix on req_item, one per
// cycle with start high while busy is low; which_list tags the list and
// last_of_list closes it; an item with no_entry set stores no triplet, so an
// empty list is closed by an item with both set. Write the four dimension
// registers through csr_valid/csr_ready/csr_index/csr_data while the block is
// idle; csr_ready is always high. The item that closes the later of the two
// lists queues a merge; the queue registers it and the back end pops it once
// idle, runs the dimension check in ST_PREP, then walks both stores at one
// result or one matched pair per cycle and closes in a final step. Each result
// appears on rsp_item for one cycle with rsp_strobe high; it waits in pend_ff
// until the next result is made or the walk closes; the last one, marked
// out_last, is sent by the closing step. busy rises only when the four-entry
// operation queue is full, which happens while a merge runs. The receiver
// cannot stall; results are never held back for it. Reset clears both lists,
// the queue and the dimension registers; the stores need no clearing.
`default_nettype none
module sparse_triplet_matrix_add
   import sptma_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_item,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data,
   output logic             rsp_strobe,
   output rsp_type          rsp_item
);

   logic   push, pop, empty, full;
   op_type push_op, head_op;

   sptma_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .full     (full),
      .push     (push),
      .push_op  (push_op)
   );

   sptma_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head_op (head_op),
      .empty   (empty),
      .full    (full)
   );

   sptma_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_op    (head_op),
      .empty      (empty),
      .pop        (pop),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
`default_nettype wire

@@ rtl/sptma_queue.sv @@
// Short FIFO of load and merge operations between front and back.
// Depends on sptma_pkg.
`default_nettype none
module sptma_queue
   import sptma_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire op_type push_op,
   input  wire logic   pop,
   output op_type      head_op,
   output logic        empty,
   output logic        full
);

   op_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wptr_ff, wptr_in;
   logic [QPTR_W-1:0]   rptr_ff, rptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign empty   = (cnt_ff == '0);
   assign full    = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_op = slot_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wptr_in = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_op;
      end
   end

endmodule
`default_nettype wire

@@ rtl/sptma_front.sv @@
// Front end: accepts input items, tracks list closing and fill, and queues
// store writes and merge requests. Depends on sptma_pkg.
`default_nettype none
module sptma_front
   import sptma_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   input  wire logic    full,
   output logic         push,
   output op_type       push_op
);

   logic             first_closed_ff, first_closed_in;
   logic             second_closed_ff, second_closed_in;
   logic [CNT_W-1:0] first_cnt_ff, first_cnt_in;
   logic [CNT_W-1:0] second_cnt_ff, second_cnt_in;
   logic             accept;
   logic             closed;
   logic [CNT_W-1:0] cnt;
   logic             wr;
   logic             merge;

   assign busy   = full;
   assign accept = start && !full;

   always_comb begin
      closed = (req_item.which_list == LIST_SECOND) ? second_closed_ff : first_closed_ff;
      cnt    = (req_item.which_list == LIST_SECOND) ? second_cnt_ff : first_cnt_ff;
      wr     = !closed && !req_item.no_entry && (cnt < CNT_W'(STORE_DEPTH));

      first_closed_in  = first_closed_ff;
      second_closed_in = second_closed_ff;
      first_cnt_in     = first_cnt_ff;
      second_cnt_in    = second_cnt_ff;
      if (accept) begin
         if (req_item.which_list == LIST_SECOND) begin
            second_closed_in = second_closed_ff | req_item.last_of_list;
            if (wr) second_cnt_in = second_cnt_ff + 1'b1;
         end else begin
            first_closed_in = first_closed_ff | req_item.last_of_list;
            if (wr) first_cnt_in = first_cnt_ff + 1'b1;
         end
      end
      merge = accept && first_closed_in && second_closed_in;
      if (merge) begin
         first_closed_in  = 1'b0;
         second_closed_in = 1'b0;
         first_cnt_in     = '0;
         second_cnt_in    = '0;
      end

      push          = accept && (wr || merge);
      push_op.wr    = wr;
      push_op.list  = req_item.which_list;
      push_op.merge = merge;
      push_op.entry = {req_item.row, req_item.col, req_item.value};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_closed_ff  <= 1'b0;
         second_closed_ff <= 1'b0;
         first_cnt_ff     <= '0;
         second_cnt_ff    <= '0;
      end else begin
         first_closed_ff  <= first_closed_in;
         second_closed_ff <= second_closed_in;
         first_cnt_ff     <= first_cnt_in;
         second_cnt_ff    <= second_cnt_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/sptma_back.sv @@
// Back end: list stores, dimension registers and the merge sequencer that
// walks both stores and drives the result port. Depends on sptma_pkg.
`default_nettype none
module sptma_back
   import sptma_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire op_type      head_op,
   input  wire logic        empty,
   output logic             pop,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data,
   output logic             rsp_strobe,
   output rsp_type          rsp_item
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_PREP  = 3'b010,
      ST_MERGE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [63:0]       first_store [STORE_DEPTH];
   logic [63:0]       second_store [STORE_DEPTH];
   logic [63:0]       rd_a_ff, rd_b_ff;
   logic [CNT_W-1:0]  first_cnt_ff, first_cnt_in;
   logic [CNT_W-1:0]  second_cnt_ff, second_cnt_in;
   logic [CNT_W-1:0]  a_ff, a_in;
   logic [CNT_W-1:0]  b_ff, b_in;
   logic [NOUT_W-1:0] n_ff, n_in;
   logic [15:0]       first_rows_ff, first_cols_ff, second_rows_ff, second_cols_ff;
   logic              pend_valid_ff, pend_valid_in;
   rsp_type           pend_ff, pend_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_item_ff, rsp_item_in;
   logic              has_a, has_b, room;
   logic              produce;
   logic [63:0]       pick;
   logic [31:0]       pick_val;
   logic [31:0]       sum;
   logic              wr_first, wr_second;

   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   assign pop       = (state_ff == ST_IDLE) && !empty;
   assign wr_first  = pop && head_op.wr && (head_op.list == LIST_FIRST);
   assign wr_second = pop && head_op.wr && (head_op.list == LIST_SECOND);

   always_comb begin
      state_in       = state_ff;
      first_cnt_in   = first_cnt_ff;
      second_cnt_in  = second_cnt_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      n_in           = n_ff;
      pend_valid_in  = pend_valid_ff;
      pend_in        = pend_ff;
      rsp_strobe_in  = 1'b0;
      rsp_item_in    = rsp_item_ff;
      has_a          = a_ff < first_cnt_ff;
      has_b          = b_ff < second_cnt_ff;
      room           = n_ff < NOUT_W'(CAP_USE);
      sum            = rd_a_ff[31:0] + rd_b_ff[31:0];
      produce        = 1'b0;
      pick           = rd_a_ff;
      pick_val       = rd_a_ff[31:0];

      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               if (wr_first) first_cnt_in = first_cnt_ff + 1'b1;
               if (wr_second) second_cnt_in = second_cnt_ff + 1'b1;
               if (head_op.merge) state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (first_rows_ff != second_rows_ff || first_cols_ff != second_cols_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_item_in   = '{out_row: '0, out_col: '0, out_value: '0, out_valid: 1'b0,
                                 status: STATUS_MISMATCH, out_last: 1'b1};
               first_cnt_in  = '0;
               second_cnt_in = '0;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            if (has_a && has_b && room) begin
               if (rd_a_ff[63:32] == rd_b_ff[63:32]) begin
                  a_in     = a_ff + 1'b1;
                  b_in     = b_ff + 1'b1;
                  produce  = (sum != 32'd0);
                  pick_val = sum;
               end else if (rd_a_ff[63:32] < rd_b_ff[63:32]) begin
                  a_in    = a_ff + 1'b1;
                  produce = 1'b1;
               end else begin
                  b_in     = b_ff + 1'b1;
                  produce  = 1'b1;
                  pick     = rd_b_ff;
                  pick_val = rd_b_ff[31:0];
               end
            end else if (has_a && room) begin
               a_in    = a_ff + 1'b1;
               produce = 1'b1;
            end else if (has_b && room) begin
               b_in     = b_ff + 1'b1;
               produce  = 1'b1;
               pick     = rd_b_ff;
               pick_val = rd_b_ff[31:0];
            end else begin
               rsp_strobe_in = 1'b1;
               if (pend_valid_ff) begin
                  rsp_item_in          = pend_ff;
                  rsp_item_in.out_last = 1'b1;
               end else begin
                  rsp_item_in = '{out_row: '0, out_col: '0, out_value: '0, out_valid: 1'b0,
                                  status: STATUS_OK, out_last: 1'b1};
               end
               pend_valid_in = 1'b0;
               first_cnt_in  = '0;
               second_cnt_in = '0;
               a_in          = '0;
               b_in          = '0;
               n_in          = '0;
               state_in      = ST_IDLE;
            end
            if (produce) begin
               if (pend_valid_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_item_in   = pend_ff;
               end
               pend_valid_in = 1'b1;
               pend_in       = '{out_row: pick[63:48], out_col: pick[47:32],
                                 out_value: pick_val, out_valid: 1'b1,
                                 status: STATUS_OK, out_last: 1'b0};
               n_in          = n_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         first_cnt_ff   <= '0;
         second_cnt_ff  <= '0;
         a_ff           <= '0;
         b_ff           <= '0;
         n_ff           <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
         first_rows_ff  <= '0;
         first_cols_ff  <= '0;
         second_rows_ff <= '0;
         second_cols_ff <= '0;
      end else begin
         state_ff      <= state_in;
         first_cnt_ff  <= first_cnt_in;
         second_cnt_ff <= second_cnt_in;
         a_ff          <= a_in;
         b_ff          <= b_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FIRST_ROWS:  first_rows_ff  <= csr_data;
               CSR_FIRST_COLS:  first_cols_ff  <= csr_data;
               CSR_SECOND_ROWS: second_rows_ff <= csr_data;
               CSR_SECOND_COLS: second_cols_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      rsp_item_ff <= rsp_item_in;
   end

   always_ff @(posedge clock) begin
      if (wr_first) begin
         first_store[first_cnt_ff[ADDR_W-1:0]] <= head_op.entry;
      end
      if (wr_second) begin
         second_store[second_cnt_ff[ADDR_W-1:0]] <= head_op.entry;
      end
      rd_a_ff <= first_store[a_in[ADDR_W-1:0]];
      rd_b_ff <= second_store[b_in[ADDR_W-1:0]];
   end

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for sparse_triplet_matrix_add: a scoreboard class predicts
// the merged triplet results, and plain tasks drive loads and dimension writes.
// Depends on sptma_pkg and the sparse_triplet_matrix_add RTL.
package sptma_tb_pkg;
   import sptma_pkg::*;

   typedef struct packed {
      logic [15:0] row;
      logic [15:0] col;
      logic [31:0] value;
   } triplet_type;

   typedef triplet_type triplet_q[$];

   class matrix_sum_scoreboard;
      logic [15:0]  dims [4] = '{default: '0};
      triplet_type  lists [2][STORE_DEPTH];
      int unsigned  fill [2] = '{0, 0};
      bit           closed [2] = '{0, 0};
      rsp_type      sums_due [$];
      int unsigned  mismatches = 0;

      function void note_dim(logic [1:0] index, logic [15:0] data);
         dims[index] = data;
      endfunction

      function int pending_count();
         return sums_due.size();
      endfunction

      function void push_flag(logic status);
         rsp_type r;
         r = '0;
         r.status = status;
         r.out_last = 1'b1;
         sums_due.push_back(r);
      endfunction

      function void push_triplet(triplet_type e, logic [31:0] total);
         rsp_type r;
         r.out_row = e.row;
         r.out_col = e.col;
         r.out_value = total;
         r.out_valid = 1'b1;
         r.status = STATUS_OK;
         r.out_last = 1'b0;
         sums_due.push_back(r);
      endfunction

      function void merge_sums();
         int unsigned a, b, made;
         triplet_type ea, eb;
         logic [31:0] total;
         rsp_type tail;
         if (dims[CSR_FIRST_ROWS] != dims[CSR_SECOND_ROWS] ||
             dims[CSR_FIRST_COLS] != dims[CSR_SECOND_COLS]) begin
            push_flag(STATUS_MISMATCH);
            return;
         end
         a = 0;
         b = 0;
         made = 0;
         while ((a < fill[0] || b < fill[1]) && made < CAP_USE) begin
            ea = '0;
            eb = '0;
            if (a < fill[0]) ea = lists[0][a];
            if (b < fill[1]) eb = lists[1][b];
            if (a < fill[0] && b < fill[1] && {ea.row, ea.col} == {eb.row, eb.col}) begin
               total = ea.value + eb.value;
               if (total != 0) begin
                  push_triplet(ea, total);
                  made++;
               end
               a++;
               b++;
            end else if (b >= fill[1] || (a < fill[0] && {ea.row, ea.col} < {eb.row, eb.col})) begin
               push_triplet(ea, ea.value);
               made++;
               a++;
            end else begin
               push_triplet(eb, eb.value);
               made++;
               b++;
            end
         end
         if (made == 0) begin
            push_flag(STATUS_OK);
         end else begin
            tail = sums_due.pop_back();
            tail.out_last = 1'b1;
            sums_due.push_back(tail);
         end
      endfunction

      function void absorb_item(req_type t);
         int w;
         w = (t.which_list == LIST_SECOND) ? 1 : 0;
         if (closed[w]) return;
         if (!t.no_entry && fill[w] < STORE_DEPTH) begin
            lists[w][fill[w]] = {t.row, t.col, t.value};
            fill[w]++;
         end
         if (t.last_of_list) closed[w] = 1'b1;
         if (closed[0] && closed[1]) begin
            merge_sums();
            fill = '{0, 0};
            closed = '{0, 0};
         end
      endfunction

      function void compare_field(string name, logic [31:0] expected, logic [31:0] actual);
         if (actual !== expected) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
            mismatches++;
         end
      endfunction

      function void check_triplet(rsp_type got);
         rsp_type want;
         if (sums_due.size() == 0) begin
            $error("unexpected result: row 0x%0h col 0x%0h value 0x%0h last %0b",
                   got.out_row, got.out_col, got.out_value, got.out_last);
            mismatches++;
            return;
         end
         want = sums_due.pop_front();
         compare_field("out_row", 32'(want.out_row), 32'(got.out_row));
         compare_field("out_col", 32'(want.out_col), 32'(got.out_col));
         compare_field("out_value", want.out_value, got.out_value);
         compare_field("out_valid", 32'(want.out_valid), 32'(got.out_valid));
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("out_last", 32'(want.out_last), 32'(got.out_last));
      endfunction
   endclass
endpackage

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sptma_pkg::*;
   import sptma_tb_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_item = '0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_FIRST_ROWS;
   logic [15:0] csr_data = '0;
   logic        rsp_strobe;
   rsp_type     rsp_item;

   matrix_sum_scoreboard board;
   int gap_pct = 34;
   int loaded = 0;

   sparse_triplet_matrix_add DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_triplet(rsp_item);
   end

   function automatic req_type make_item(logic which, logic [15:0] row, logic [15:0] col,
                                         logic [31:0] value, logic no_entry, logic closes);
      req_type t;
      t.which_list = which;
      t.row = row;
      t.col = col;
      t.value = value;
      t.no_entry = no_entry;
      t.last_of_list = closes;
      return t;
   endfunction

   function automatic triplet_type random_triplet(bit narrow);
      triplet_type t;
      t.row = narrow ? 16'($urandom_range(7)) : 16'($urandom);
      t.col = narrow ? 16'($urandom_range(7)) : 16'($urandom);
      case ($urandom_range(7))
         0: t.value = 32'h7fff_ffff;
         1: t.value = 32'h8000_0000;
         2: t.value = 32'($urandom_range(3));
         default: t.value = $urandom;
      endcase
      return t;
   endfunction

   function automatic triplet_q by_position(triplet_q q);
      triplet_type t;
      int j;
      for (int i = 1; i < q.size(); i++) begin
         t = q[i];
         j = i - 1;
         while (j >= 0 && {q[j].row, q[j].col} > {t.row, t.col}) begin
            q[j + 1] = q[j];
            j--;
         end
         q[j + 1] = t;
      end
      return q;
   endfunction

   task automatic send_item(input req_type t);
      while ($urandom_range(99) < gap_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_item = t;
      do @(posedge clock); while (busy);
      board.absorb_item(t);
      loaded++;
      @(negedge clock);
   endtask

   task automatic drain();
      start = 1'b0;
      while (board.pending_count() != 0) @(negedge clock);
   endtask

   task automatic write_dim(input logic [1:0] index, input logic [15:0] data);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      board.note_dim(index, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_dims(input logic [15:0] fr, input logic [15:0] fc,
                           input logic [15:0] sr, input logic [15:0] sc);
      drain();
      repeat (12) @(negedge clock);
      write_dim(CSR_FIRST_ROWS, fr);
      write_dim(CSR_FIRST_COLS, fc);
      write_dim(CSR_SECOND_ROWS, sr);
      write_dim(CSR_SECOND_COLS, sc);
   endtask

   task automatic run_addition(input int na, input int nb);
      triplet_q    side [2];
      int          pos [2];
      bit          shut [2];
      bit          tail_closer [2];
      bit          narrow;
      logic        w;
      logic        closes;
      logic        nop;
      triplet_type t;
      narrow = (na + nb <= 20) && ($urandom_range(3) != 0);
      side[0] = {};
      side[1] = {};
      for (int i = 0; i < na; i++) side[0].push_back(random_triplet(narrow));
      for (int i = 0; i < nb; i++) begin
         if (na > 0 && $urandom_range(1) == 1) begin
            t = side[0][$urandom_range(na - 1)];
            case ($urandom_range(2))
               0: t.value = -t.value;
               1: t.value = $urandom;
               default: ;
            endcase
         end else begin
            t = random_triplet(narrow);
         end
         side[1].push_back(t);
      end
      if ($urandom_range(7) != 0) begin
         side[0] = by_position(side[0]);
         side[1] = by_position(side[1]);
      end
      for (int s = 0; s < 2; s++) begin
         pos[s] = 0;
         shut[s] = 1'b0;
         tail_closer[s] = side[s].size() == 0 || $urandom_range(3) == 0;
      end
      while (!(shut[0] && shut[1])) begin
         w = shut[0] ? 1'b1 : shut[1] ? 1'b0 : 1'($urandom_range(1));
         if ($urandom_range(9) == 0) begin
            // noise: a no-op on an open list, anything on a closed one
            t = random_triplet(1'b0);
            w = 1'($urandom_range(1));
            nop = !shut[w] || 1'($urandom_range(1));
            closes = shut[w] && 1'($urandom_range(1));
            send_item(make_item(w, t.row, t.col, t.value, nop, closes));
         end else if (pos[w] < side[w].size()) begin
            t = side[w][pos[w]];
            pos[w]++;
            closes = pos[w] == side[w].size() && !tail_closer[w];
            send_item(make_item(w, t.row, t.col, t.value, 1'b0, closes));
            shut[w] = closes;
         end else begin
            t = random_triplet(1'b0);
            send_item(make_item(w, t.row, t.col, t.value, 1'b1, 1'b1));
            shut[w] = 1'b1;
         end
      end
   endtask

   initial begin
      int          additions;
      int          na, nb;
      int          guard;
      logic [15:0] r, c;
      board = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_dims(16'hffff, 16'hffff, 16'hffff, 16'hffff);
      send_item(make_item(LIST_FIRST, 16'hffff, 16'hffff, 32'hffff_ffff, 1'b1, 1'b1));
      send_item(make_item(LIST_SECOND, 16'h0, 16'h0, 32'h0, 1'b1, 1'b1));
      send_item(make_item(LIST_FIRST, 16'h0, 16'h0, 32'h7fff_ffff, 1'b0, 1'b1));
      send_item(make_item(LIST_SECOND, 16'h0, 16'h0, 32'h1, 1'b0, 1'b1));
      send_item(make_item(LIST_FIRST, 16'hffff, 16'hffff, 32'h5, 1'b0, 1'b1));
      send_item(make_item(LIST_SECOND, 16'hffff, 16'hffff, 32'hffff_fffb, 1'b0, 1'b1));
      send_item(make_item(LIST_FIRST, 16'h1, 16'h2, 32'ha, 1'b0, 1'b0));
      send_item(make_item(LIST_SECOND, 16'h1, 16'h1, 32'h3, 1'b0, 1'b0));
      send_item(make_item(LIST_FIRST, 16'h7, 16'h7, 32'h7, 1'b1, 1'b0));
      send_item(make_item(LIST_FIRST, 16'h2, 16'h0, 32'hffff_ffff, 1'b0, 1'b1));
      send_item(make_item(LIST_FIRST, 16'h9, 16'h9, 32'h9, 1'b0, 1'b0));
      send_item(make_item(LIST_SECOND, 16'h3, 16'h3, 32'h8000_0000, 1'b0, 1'b1));
      send_item(make_item(LIST_SECOND, 16'h0, 16'h1, 32'h4, 1'b0, 1'b1));
      send_item(make_item(LIST_FIRST, 16'h0, 16'h0, 32'h1, 1'b0, 1'b0));
      send_item(make_item(LIST_FIRST, 16'h0, 16'h0, 32'h0, 1'b1, 1'b1));
      send_item(make_item(LIST_FIRST, 16'h5, 16'h5, 32'h1, 1'b0, 1'b0));
      send_item(make_item(LIST_FIRST, 16'h0, 16'h0, 32'h2, 1'b0, 1'b1));
      send_item(make_item(LIST_SECOND, 16'h3, 16'h3, 32'h3, 1'b0, 1'b1));
      set_dims(16'h4, 16'h4, 16'h5, 16'h4);
      send_item(make_item(LIST_FIRST, 16'h0, 16'h0, 32'h1, 1'b0, 1'b1));
      send_item(make_item(LIST_SECOND, 16'h0, 16'h0, 32'h0, 1'b1, 1'b1));
      set_dims(16'h0, 16'h0, 16'h0, 16'h1);
      send_item(make_item(LIST_SECOND, 16'h0, 16'h0, 32'h0, 1'b1, 1'b1));
      send_item(make_item(LIST_FIRST, 16'h0, 16'h0, 32'h0, 1'b1, 1'b1));
      set_dims(16'h0, 16'h0, 16'h0, 16'h0);
      send_item(make_item(LIST_FIRST, 16'h0, 16'h0, 32'h0, 1'b0, 1'b1));
      send_item(make_item(LIST_SECOND, 16'h0, 16'h0, 32'h0, 1'b0, 1'b1));

      additions = 0;
      while (loaded < 210) begin
         gap_pct = (additions >= 6 && additions < 14) ? 0 : 34;
         if (additions % 5 == 0 || $urandom_range(5) == 0) begin
            r = 16'($urandom);
            c = 16'($urandom);
            case ($urandom_range(7))
               0: set_dims(r, c, r ^ 16'(1 << $urandom_range(15)), c);
               1: set_dims(r, c, r, c ^ 16'(1 << $urandom_range(15)));
               2: set_dims(16'h0, 16'h0, 16'h0, 16'h0);
               3: set_dims(16'hffff, 16'hffff, 16'hffff, 16'hffff);
               default: set_dims(r, c, r, c);
            endcase
         end else if ($urandom_range(5) == 0) begin
            drain();
         end
         if (additions == 0) begin
            na = 34;
            nb = 20;
         end else if ($urandom_range(9) == 0) begin
            na = $urandom_range(36, 16);
            nb = $urandom_range(36, 16);
         end else begin
            na = $urandom_range(6);
            nb = $urandom_range(6);
         end
         run_addition(na, nb);
         additions++;
      end

      start = 1'b0;
      guard = 0;
      while (board.pending_count() != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (80) @(negedge clock);
      if (board.mismatches == 0 && board.pending_count() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
